[hdl/letter_histogram_mode_score_defines.svh]
// Assertion macros shared by the letter histogram block.
`ifndef LETTER_HISTOGRAM_MODE_SCORE_DEFINES_SVH
`define LETTER_HISTOGRAM_MODE_SCORE_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define LHMS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define LHMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/lhms_pkg.sv]
// Shared types, constants and helper functions of the letter histogram block.
package lhms_pkg;

	localparam int CNT_W    = 20;
	localparam int NUM_BINS = 52;
	localparam int BIN_W    = $clog2(NUM_BINS);
	localparam int OUT_W    = 20;
	localparam int SCORE_W  = OUT_W + 1;
	localparam int DOC_W    = 20;
	localparam int LETTERS  = 26;

	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	// Letter decode result
	typedef struct packed {
		logic             hit;
		logic [BIN_W-1:0] idx;
	} bin_sel_t;

	// Request from the engine to the bin memory
	typedef struct packed {
		logic             clr;
		logic             we;
		logic [BIN_W-1:0] waddr;
		logic [CNT_W-1:0] wdata;
		logic [BIN_W-1:0] raddr;
	} mem_req_t;

	// Finished result handed from the engine to the output stage
	typedef struct packed {
		logic [OUT_W-1:0] max_count;
		logic             count_error;
	} result_t;

	// Map a byte to its bin: 'A'..'Z' to 0..25, 'a'..'z' to 26..51
	function automatic bin_sel_t letter_bin(input logic [7:0] b);
		bin_sel_t   sel;
		logic [7:0] off;
		sel = '0;
		off = '0;
		if (b >= 8'h41 && b <= 8'h5A) begin
			off     = b - 8'h41;
			sel.hit = 1'b1;
			sel.idx = off[BIN_W-1:0];
		end else if (b >= 8'h61 && b <= 8'h7A) begin
			off     = b - 8'h61 + 8'(LETTERS);
			sel.hit = 1'b1;
			sel.idx = off[BIN_W-1:0];
		end
		return sel;
	endfunction

	// Clamp a bin count to the output width
	function automatic logic [OUT_W-1:0] clamp_out(input logic [CNT_W-1:0] c);
		logic [OUT_W-1:0] r;
		r = OUT_W'(c);
		if (CNT_W > OUT_W) begin
			if (c > CNT_W'(OUT_MAX))
				r = OUT_MAX;
		end
		return r;
	endfunction

endpackage

[hdl/lhms_bin_mem.sv]
// Bin count memory with one write and one registered read port, and per-entry valid bits.
module lhms_bin_mem
	import lhms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mem_req_t         req,
	output logic [CNT_W-1:0] rdata
);

	logic [CNT_W-1:0]    mem_q [NUM_BINS];
	logic [NUM_BINS-1:0] valid_q;
	logic [CNT_W-1:0]    rdata_q;
	logic                rvalid_q;

	// Write the storage array and register the read data
	always_ff @(posedge clk) begin
		if (req.we)
			mem_q[req.waddr] <= req.wdata;
		rdata_q <= mem_q[req.raddr];
	end

	// Track which entries hold a written count; clear drops them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= valid_q[req.raddr];
			if (req.clr)
				valid_q <= '0;
			else if (req.we)
				valid_q[req.waddr] <= 1'b1;
		end
	end

	// An entry not written since reset or clear reads as zero
	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

[hdl/lhms_engine.sv]
// Sequencer: read-modify-write of one bin for a letter update, then a scan of all bins for the maximum.
module lhms_engine
	import lhms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       in_action,
	input  logic [7:0]       in_byte,
	input  logic             in_empty,
	output mem_req_t         mem_req,
	input  logic [CNT_W-1:0] mem_rdata,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MODIFY,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic             add_q;
	logic [BIN_W-1:0] bin_q;
	logic [BIN_W-1:0] scan_idx_q;
	logic             data_valid_s1;
	logic [CNT_W-1:0] best_q;
	logic             err_q;

	bin_sel_t         sel;
	logic             accept;
	logic             is_update;
	logic             is_clear;
	logic             sat;
	logic [CNT_W-1:0] best_next;

	// Decode the incoming item
	always_comb begin
		sel       = letter_bin(in_byte);
		accept    = in_valid && in_ready;
		is_update = 1'b0;
		is_clear  = 1'b0;
		unique case (action_t'(in_action))
			ACT_ADD, ACT_REMOVE: is_update = !in_empty && sel.hit;
			ACT_CLEAR:           is_clear  = 1'b1;
			default:             is_update = 1'b0;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	// Saturation check and memory requests
	always_comb begin
		sat = add_q ? (mem_rdata == {CNT_W{1'b1}}) : (mem_rdata == '0);
		mem_req.clr   = accept && is_clear;
		mem_req.we    = (state_q == ST_MODIFY) && !sat;
		mem_req.waddr = bin_q;
		mem_req.wdata = add_q ? mem_rdata + 1'b1 : mem_rdata - 1'b1;
		mem_req.raddr = (state_q == ST_IDLE) ? sel.idx : scan_idx_q;
	end

	// Running maximum over scanned entries
	assign best_next = (data_valid_s1 && mem_rdata > best_q) ? mem_rdata : best_q;

	// Hold state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			add_q         <= 1'b0;
			bin_q         <= '0;
			scan_idx_q    <= '0;
			data_valid_s1 <= 1'b0;
			best_q        <= '0;
			err_q         <= 1'b0;
		end else begin
			data_valid_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						add_q      <= (action_t'(in_action) == ACT_ADD);
						bin_q      <= sel.idx;
						scan_idx_q <= '0;
						best_q     <= '0;
						err_q      <= 1'b0;
						state_q    <= is_update ? ST_MODIFY : ST_SCAN;
					end
				end
				ST_MODIFY: begin
					err_q   <= sat;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					best_q <= best_next;
					// Stop the address at the last bin so it never leaves the array
					if (scan_idx_q == BIN_W'(NUM_BINS - 1))
						state_q <= ST_LAST;
					else
						scan_idx_q <= scan_idx_q + 1'b1;
				end
				ST_LAST: begin
					best_q  <= best_next;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid       = (state_q == ST_DONE);
	assign res.max_count   = clamp_out(best_q);
	assign res.count_error = err_q;

endmodule

[hdl/letter_histogram_mode_score.sv]
// Top level: letter histogram with maximum bin count and score output.
//
// An item runs through these steps from acceptance to the result handshake:
// the addressed bin is read at acceptance, then written back, then every one
// of the 52 bins is read out of the bin memory through its single read port,
// the last read is folded in, the result is handed to the output register
// and shown there. Items that change no bin (clear, non-letter, empty word,
// unused action) skip the write-back. A new item is accepted only after the
// previous one has handed its result to the output register.
// Clear takes effect at once through per-bin valid bits; no sweep is needed.
// The output register lets the next item be accepted while a result waits.
// doc_size is written through the cfg channel, which is always ready; write it
// only while no item is in flight.
`include "letter_histogram_mode_score_defines.svh"

module letter_histogram_mode_score
	import lhms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [DOC_W-1:0] cfg_data,   // doc_size
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,    // first_byte
	input  logic [2:0]       s_tuser,    // action[1:0], word_empty[2]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [47:0]      m_tdata,    // max_count[19:0], score[40:20], zero fill
	output logic [0:0]       m_tuser     // count_error
);

	logic [DOC_W-1:0]   doc_size_q;
	mem_req_t           mem_req;
	logic [CNT_W-1:0]   mem_rdata;
	logic               res_valid;
	logic               res_ready;
	result_t            res;
	logic [SCORE_W-1:0] score;
	logic               out_valid_q;
	logic [OUT_W-1:0]   max_q;
	logic [SCORE_W-1:0] score_q;
	logic               err_q;

	lhms_bin_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata)
	);

	lhms_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tuser[1:0]),
		.in_byte   (s_tdata),
		.in_empty  (s_tuser[2]),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Hold the document word count
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			doc_size_q <= '0;
		else if (cfg_valid && cfg_ready)
			doc_size_q <= cfg_data;
	end

	// Score is the maximum minus the document size; both fit in the signed width
	assign score = {1'b0, res.max_count} - {1'b0, doc_size_q};

	// Output register: load when empty or being drained
	assign res_ready = !out_valid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_ready)
			out_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			max_q   <= res.max_count;
			score_q <= score;
			err_q   <= res.count_error;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(48 - OUT_W - SCORE_W){1'b0}}, score_q, max_q};
	assign m_tuser  = err_q;

	// One item in flight: input closes right after an accept
	`LHMS_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready,
		"input accepted again while an item is in flight")
	// No new item while a result waits in the engine
	`LHMS_ASSERT_SAME(a_busy_done, clk, arst_n, res_valid, !s_tready,
		"input ready while the engine holds a result")
	// A handed-over result shows up at the output next cycle
	`LHMS_ASSERT_NEXT(a_out_load, clk, arst_n, res_valid && res_ready, m_tvalid,
		"result lost between engine and output register")

endmodule
